### rtl/gds_pkg.sv
package gds_pkg;

    localparam int MAX_INDIV   = 4096;
    localparam int STORE_DEPTH = (MAX_INDIV + 3) / 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int N_W         = 13;
    localparam int CNT_W       = 13;
    localparam int LOADED_W    = 11;
    localparam int VAL_W       = 32;
    localparam int OUT_DATA_W  = 136;
    localparam int IN_DATA_W   = 24;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    localparam logic [0:0] REG_INDIV_COUNT = 1'b0;
    localparam logic [0:0] REG_MAF_THRESH  = 1'b1;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_FIN
    } top_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_KEEP,
        F_MAG,
        F_SQ,
        F_R,
        F_DIV,
        F_SAT,
        F_SQRT,
        F_STORE
    } fin_state_t;

    typedef struct packed {
        logic             start;
        logic [N_W-1:0]   n_eff;
        logic [15:0]      maf;
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c2;
        logic [CNT_W-1:0] c3;
    } fin_req_t;

    typedef struct packed {
        logic             busy;
        logic             keep;
        logic [VAL_W-1:0] val_a;
        logic [VAL_W-1:0] val_b;
        logic [VAL_W-1:0] val_c;
    } fin_stat_t;

    // Genotype code to class: missing, hom1, het, hom2 are classes 0..3.
    function automatic logic [1:0] code_class(input logic [1:0] code);
        logic [1:0] cls;
        case (code)
            2'd0:    cls = 2'd1;
            2'd1:    cls = 2'd0;
            2'd2:    cls = 2'd2;
            default: cls = 2'd3;
        endcase
        return cls;
    endfunction

endpackage

### rtl/gds_ram.sv
module gds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/gds_finish.sv
module gds_finish import gds_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  fin_req_t  req,
    output fin_stat_t stat
);

    fin_state_t state_reg, state_next;

    logic [N_W-1:0]   nv_reg;
    logic [12:0]      n_reg;
    logic [13:0]      s_reg;
    logic [14:0]      q_reg;
    logic [1:0]       nz_reg;
    logic [15:0]      maf_reg;
    logic [25:0]      nn_reg;
    logic [27:0]      ss_reg;
    logic [29:0]      tn_reg;
    logic [40:0]      a_reg;
    logic [40:0]      b_reg;
    logic [40:0]      v_reg;
    logic             keep_reg;
    logic [1:0]       x_reg;
    logic [13:0]      mag_reg;
    logic             neg_reg;
    logic [27:0]      mm_reg;
    logic [72:0]      dq_reg;
    logic [40:0]      rem_reg;
    logic [6:0]       cnt_reg;
    logic [62:0]      sx_reg;
    logic [63:0]      res_reg;
    logic [62:0]      bit_reg;
    logic [VAL_W-1:0] val_reg [3];

    logic [13:0] two_n;
    logic [13:0] m1;
    logic [13:0] m2;
    logic [40:0] v_calc;
    logic        keep_calc;
    logic [13:0] xn;
    logic [41:0] div_t;
    logic        div_ge;
    logic [63:0] sq_sum;
    logic        sq_ge;
    logic [31:0] z_cap;

    always_comb
    begin
        two_n     = {n_reg, 1'b0};
        m1        = (s_reg <= two_n) ? s_reg : two_n;
        m2        = ((two_n - m1) < m1) ? (two_n - m1) : m1;
        v_calc    = (a_reg > b_reg) ? (a_reg - b_reg) : 41'd0;
        keep_calc = (nz_reg >= 2'd2) && (v_calc != 41'd0) && ({m2, 16'b0} >= tn_reg);
        case (x_reg)
            2'd0:    xn = 14'd0;
            2'd1:    xn = {1'b0, nv_reg};
            default: xn = {nv_reg, 1'b0};
        endcase
        div_t  = {rem_reg, dq_reg[72]};
        div_ge = div_t >= {1'b0, v_reg};
        sq_sum = res_reg + {1'b0, bit_reg};
        sq_ge  = {1'b0, sx_reg} >= sq_sum;
        z_cap  = (res_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res_reg[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (req.start) state_next = F_MUL1;
            F_MUL1:  state_next = F_MUL2;
            F_MUL2:  state_next = F_KEEP;
            F_KEEP:  state_next = keep_calc ? F_MAG : F_IDLE;
            F_MAG:   state_next = F_SQ;
            F_SQ:    state_next = F_R;
            F_R:     state_next = F_DIV;
            F_DIV:   if (cnt_reg == 7'd72) state_next = F_SAT;
            F_SAT:   state_next = F_SQRT;
            F_SQRT:  if (cnt_reg == 7'd31) state_next = F_STORE;
            F_STORE: state_next = (x_reg == 2'd2) ? F_IDLE : F_MAG;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        stat.busy  = state_reg != F_IDLE;
        stat.keep  = keep_reg;
        stat.val_a = val_reg[0];
        stat.val_b = val_reg[1];
        stat.val_c = val_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            keep_reg   <= 1'b0;
            val_reg[0] <= '0;
            val_reg[1] <= '0;
            val_reg[2] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_KEEP)
            begin
                keep_reg <= keep_calc;
                if (!keep_calc)
                begin
                    val_reg[0] <= '0;
                    val_reg[1] <= '0;
                    val_reg[2] <= '0;
                end
            end
            if (state_reg == F_STORE)
            begin
                val_reg[x_reg] <= neg_reg ? (32'd0 - z_cap) : z_cap;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                nv_reg  <= req.n_eff;
                maf_reg <= req.maf;
                n_reg   <= (req.n_eff > req.c0) ? (req.n_eff - req.c0) : 13'd0;
                s_reg   <= {1'b0, req.c2} + {req.c3, 1'b0};
                q_reg   <= {2'b0, req.c2} + {req.c3, 2'b0};
                nz_reg  <= {1'b0, req.c1 != '0} + {1'b0, req.c2 != '0}
                           + {1'b0, req.c3 != '0};
            end
            F_MUL1:
            begin
                nn_reg <= nv_reg * nv_reg;
                ss_reg <= s_reg * s_reg;
                tn_reg <= maf_reg * two_n;
            end
            F_MUL2:
            begin
                a_reg <= nn_reg * q_reg;
                b_reg <= ss_reg * n_reg;
            end
            F_KEEP:
            begin
                v_reg <= v_calc;
                x_reg <= 2'd0;
            end
            F_MAG:
            begin
                neg_reg <= xn < s_reg;
                mag_reg <= (xn < s_reg) ? (s_reg - xn) : (xn - s_reg);
            end
            F_SQ:
            begin
                mm_reg <= mag_reg * mag_reg;
            end
            F_R:
            begin
                dq_reg  <= {41'(mm_reg) * 41'(nv_reg - 13'd1), 32'b0};
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            F_DIV:
            begin
                // One quotient bit per cycle, dividend bits shift out at the top.
                rem_reg <= div_ge ? (div_t[40:0] - v_reg) : div_t[40:0];
                dq_reg  <= {dq_reg[71:0], div_ge};
                cnt_reg <= cnt_reg + 7'd1;
            end
            F_SAT:
            begin
                sx_reg  <= (dq_reg > (73'd1 << 62)) ? (63'd1 << 62) : dq_reg[62:0];
                res_reg <= '0;
                bit_reg <= 63'd1 << 62;
                cnt_reg <= '0;
            end
            F_SQRT:
            begin
                if (sq_ge)
                begin
                    sx_reg  <= sx_reg - sq_sum[62:0];
                    res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 7'd1;
            end
            F_STORE:
            begin
                x_reg <= x_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/genotype_decode_standardize.sv
// Genotype decode and standardize. Load beats (tuser = 0) bring the packed 2-bit genotype
// bytes of one variant in order; the byte that completes ceil(N/4) bytes produces one
// summary beat with the keep flag and the Q15.16 standardized values of hom1, het and hom2.
// After the last byte is accepted, registered steps form the products and the keep test;
// then each of the three genotype classes in turn passes a shared bit-serial divider and
// square-root unit, and the summary is loaded into the output register once it is free. A
// variant that fails the tests skips the per-class work. A readout beat (tuser = 1) goes
// through the registered read of the byte store. No input beat is taken until the summary
// or readout is loaded, but an input beat is taken while a result still waits on the
// output. Configuration is written over the APB port at byte address 0 (N) and 4 (minor
// allele threshold, Q0.16).
module genotype_decode_standardize import gds_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // packed_byte [7:0], group_index [17:8], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // keep [0], value_a [32:1], value_b [64:33], value_c [96:65], value_d [128:97],
    // lanes_valid [131:129], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic                  m_tuser
);

    top_state_t state_reg, state_next;

    logic [N_W-1:0]        indiv_count_reg;
    logic [15:0]           maf_reg;
    logic [LOADED_W-1:0]   loaded_reg;
    logic [CNT_W-1:0]      cnt_reg [4];
    logic [CNT_W-1:0]      cnt_next [4];
    logic [ADDR_W-1:0]     g_reg;
    logic                  m_valid_reg;
    logic                  m_kind_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [N_W-1:0]    n_eff;
    logic [LOADED_W-1:0] total;
    logic              accept;
    logic              out_free;
    logic              is_last;
    logic [N_W-1:0]    load_base;
    logic [2:0]        load_lanes;
    logic [N_W-1:0]    rd_base;
    logic [2:0]        rd_lanes;
    logic [7:0]        rd_byte;
    logic [VAL_W-1:0]  rd_val [4];
    logic [1:0]        cls;
    logic [1:0]        rcls;
    fin_req_t          fin_req;
    fin_stat_t         fin_stat;
    logic              load_summary;
    logic              load_readout;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MAF_THRESH) ? {16'b0, maf_reg}
                                                    : {19'b0, indiv_count_reg};

    always_comb
    begin
        if (indiv_count_reg < 13'd2)
            n_eff = 13'd2;
        else if (indiv_count_reg > N_W'(MAX_INDIV))
            n_eff = N_W'(MAX_INDIV);
        else
            n_eff = indiv_count_reg;
        total = LOADED_W'((n_eff + 13'd3) >> 2);
    end

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = (loaded_reg + 11'd1) >= total;

    always_comb
    begin
        load_base  = {loaded_reg, 2'b00};
        load_lanes = 3'd0;
        if (load_base < n_eff)
            load_lanes = ((n_eff - load_base) > 13'd4) ? 3'd4 : 3'((n_eff - load_base));
        for (int c = 0; c < 4; c++)
        begin
            cnt_next[c] = cnt_reg[c];
        end
        for (int j = 0; j < 4; j++)
        begin
            cls = code_class(s_tdata[2*j +: 2]);
            if (3'(j) < load_lanes)
                cnt_next[cls] = cnt_next[cls] + 13'd1;
        end
    end

    always_comb
    begin
        fin_req.start = accept && (s_tuser == FUNC_LOAD) && is_last;
        fin_req.n_eff = n_eff;
        fin_req.maf   = maf_reg;
        fin_req.c0    = cnt_next[0];
        fin_req.c1    = cnt_next[1];
        fin_req.c2    = cnt_next[2];
        fin_req.c3    = cnt_next[3];
    end

    gds_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (accept && (s_tuser == FUNC_LOAD) && (loaded_reg < LOADED_W'(STORE_DEPTH))),
        .waddr(loaded_reg[ADDR_W-1:0]),
        .wdata(s_tdata[7:0]),
        .re   (accept && (s_tuser == FUNC_READ)),
        .raddr(s_tdata[8 +: ADDR_W]),
        .rdata(rd_byte)
    );

    gds_finish u_finish (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (fin_req),
        .stat (fin_stat)
    );

    always_comb
    begin
        rd_base  = {1'b0, g_reg, 2'b00};
        rd_lanes = 3'd0;
        if (rd_base < n_eff)
            rd_lanes = ((n_eff - rd_base) > 13'd4) ? 3'd4 : 3'((n_eff - rd_base));
        for (int j = 0; j < 4; j++)
        begin
            rcls      = code_class(rd_byte[2*j +: 2]);
            rd_val[j] = '0;
            if (3'(j) < rd_lanes)
            begin
                case (rcls)
                    2'd1:    rd_val[j] = fin_stat.val_a;
                    2'd2:    rd_val[j] = fin_stat.val_b;
                    2'd3:    rd_val[j] = fin_stat.val_c;
                    default: rd_val[j] = '0;
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_READ)
                        state_next = T_READ;
                    else if (is_last)
                        state_next = T_FIN;
                end
            end
            T_READ:  if (out_free) state_next = T_IDLE;
            T_FIN:   if (!fin_stat.busy && out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = state_reg == T_IDLE;
        load_readout = (state_reg == T_READ) && out_free;
        load_summary = (state_reg == T_FIN) && !fin_stat.busy && out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            indiv_count_reg <= 13'd4;
            maf_reg         <= '0;
            loaded_reg      <= '0;
            m_valid_reg     <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_INDIV_COUNT)
                    indiv_count_reg <= pwdata[N_W-1:0];
                else
                    maf_reg <= pwdata[15:0];
            end
            if (accept && (s_tuser == FUNC_LOAD))
            begin
                loaded_reg <= is_last ? '0 : (loaded_reg + 11'd1);
                for (int c = 0; c < 4; c++)
                begin
                    cnt_reg[c] <= is_last ? '0 : cnt_next[c];
                end
            end
            if (load_readout || load_summary)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == FUNC_READ))
            g_reg <= s_tdata[8 +: ADDR_W];
        if (load_readout)
        begin
            m_kind_reg <= KIND_READOUT;
            m_data_reg <= {4'b0, rd_lanes, rd_val[3], rd_val[2], rd_val[1], rd_val[0],
                           fin_stat.keep};
        end
        else if (load_summary)
        begin
            m_kind_reg <= KIND_SUMMARY;
            m_data_reg <= {4'b0, 3'd0, 32'd0, fin_stat.val_c, fin_stat.val_b,
                           fin_stat.val_a, fin_stat.keep};
        end
    end

endmodule
